FILE: rtl/core/lmts_pkg.sv
// Package for the LCD mode timing sequencer.
// Holds display mode codes, phase lengths, register indexes and the result word type.
// No dependencies.
package lmts_pkg;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_XFER   = 2'd3
    } t_mode;

    localparam int TICK_W = 7;
    localparam int LINE_W = 8;

    localparam logic [TICK_W-1:0] LEN_SCAN   = 7'd20;
    localparam logic [TICK_W-1:0] LEN_XFER   = 7'd43;
    localparam logic [TICK_W-1:0] LEN_HBLANK = 7'd51;
    localparam logic [TICK_W-1:0] LEN_LINE   = 7'd114;

    localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
    localparam logic [LINE_W-1:0] LINE_COUNT        = 8'd154;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HBLANK_EN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_EN   = 2'd2;

    typedef struct packed {
        logic [1:0]        display_mode;
        logic [LINE_W-1:0] current_line;
        logic              compare_flag;
        logic              status_irq;
        logic              vblank_irq;
        logic              line_render;
        logic              frame_done;
    } t_result;

endpackage

FILE: rtl/core/lmts_tick_if.sv
// Input channel of the LCD mode timing sequencer: one tick word per handshake.
// No dependencies.
interface lmts_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

FILE: rtl/core/lmts_result_if.sv
// Result channel of the LCD mode timing sequencer: mode, line, flag and pulses.
// No dependencies.
interface lmts_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] display_mode;
    logic [7:0] current_line;
    logic       compare_flag;
    logic       status_irq;
    logic       vblank_irq;
    logic       line_render;
    logic       frame_done;

    modport source (output valid, output display_mode, output current_line,
                    output compare_flag, output status_irq, output vblank_irq,
                    output line_render, output frame_done, input ready);
    modport sink   (input valid, input display_mode, input current_line,
                    input compare_flag, input status_irq, input vblank_irq,
                    input line_render, input frame_done, output ready);
endinterface

FILE: rtl/core/lcd_mode_timing_sequencer.sv
// LCD mode timing sequencer top level: mode/line/tick counters and a two-word result skid.
// Depends on lmts_pkg, lmts_tick_if and lmts_result_if.
//
//   channel    dir  handshake        word
//   i_item     in   valid/ready      tick
//   o_result   out  valid/ready      mode, line, compare flag, irq and frame pulses
//   i_cfg_*    in   write enable     index 0..2, 8-bit data
//
// One tick word per cycle while i_item.ready is high: the counter update is a single short
// compare/increment between the state registers, and each word's result is registered into
// the output word, or into the skid slot while output stalls. Two result words are buffered;
// i_item.ready drops only while both slots are full.
// Reset (synchronous, active low) puts the display in object scan on line 0, clears config.
module lcd_mode_timing_sequencer
    import lmts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lmts_tick_if.sink             i_item,
    lmts_result_if.source         o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // configuration
    logic [LINE_W-1:0] r_line_compare;
    logic              r_hblank_en;
    logic              r_compare_en;

    // sequencer state
    t_mode             r_mode,       n_mode;
    logic [LINE_W-1:0] r_line,       n_line;
    logic [TICK_W-1:0] r_tick_count, n_tick_count;
    logic              r_cmp_flag,   n_cmp_flag;

    // result buffer
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    t_result n_result;

    logic              accept;
    logic [TICK_W-1:0] tick_inc;
    logic [LINE_W-1:0] line_inc;
    logic              line_eq;
    logic              out_free;

    assign i_item.ready = !r_skid_valid;
    assign accept       = i_item.valid && !r_skid_valid;
    assign out_free     = !r_out_valid || o_result.ready;

    assign tick_inc = r_tick_count + 1'b1;
    assign line_inc = r_line + 1'b1;
    assign line_eq  = (r_line == r_line_compare);

    always_comb begin
        n_mode       = r_mode;
        n_line       = r_line;
        n_tick_count = r_tick_count;
        n_cmp_flag   = r_cmp_flag;
        n_result     = '0;
        if (i_item.tick) begin
            n_tick_count = tick_inc;
            case (r_mode)
                MODE_SCAN: begin
                    if (tick_inc >= LEN_SCAN) begin
                        n_tick_count = '0;
                        n_mode       = MODE_XFER;
                    end
                end
                MODE_XFER: begin
                    if (tick_inc >= LEN_XFER) begin
                        n_tick_count        = '0;
                        n_result.status_irq = r_hblank_en || (r_compare_en && line_eq);
                        n_cmp_flag          = line_eq;
                        n_mode              = MODE_HBLANK;
                    end
                end
                MODE_HBLANK: begin
                    if (tick_inc >= LEN_HBLANK) begin
                        n_tick_count         = '0;
                        n_result.line_render = 1'b1;
                        n_line               = line_inc;
                        if (line_inc == FIRST_VBLANK_LINE) begin
                            n_mode              = MODE_VBLANK;
                            n_result.vblank_irq = 1'b1;
                        end else begin
                            n_mode = MODE_SCAN;
                        end
                    end
                end
                default: begin
                    if (tick_inc >= LEN_LINE) begin
                        n_tick_count = '0;
                        n_line       = line_inc;
                        // leaving the last vblank line wraps to a new frame
                        if (line_inc == LINE_COUNT) begin
                            n_result.frame_done = 1'b1;
                            n_line              = '0;
                            n_mode              = MODE_SCAN;
                        end
                    end
                end
            endcase
        end
        n_result.display_mode = n_mode;
        n_result.current_line = n_line;
        n_result.compare_flag = n_cmp_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_compare <= '0;
            r_hblank_en    <= 1'b0;
            r_compare_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LINE_COMPARE: r_line_compare <= i_cfg_wdata;
                REG_HBLANK_EN:    r_hblank_en    <= i_cfg_wdata[0];
                REG_COMPARE_EN:   r_compare_en   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SCAN;
            r_line       <= '0;
            r_tick_count <= '0;
            r_cmp_flag   <= 1'b0;
        end else if (accept) begin
            r_mode       <= n_mode;
            r_line       <= n_line;
            r_tick_count <= n_tick_count;
            r_cmp_flag   <= n_cmp_flag;
        end
    end

    // output word plus one skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.display_mode = r_out.display_mode;
    assign o_result.current_line = r_out.current_line;
    assign o_result.compare_flag = r_out.compare_flag;
    assign o_result.status_irq   = r_out.status_irq;
    assign o_result.vblank_irq   = r_out.vblank_irq;
    assign o_result.line_render  = r_out.line_render;
    assign o_result.frame_done   = r_out.frame_done;

endmodule

FILE: bench/lcd_mode_timing_sequencer_tb.sv
// Self-checking bench for lcd_mode_timing_sequencer: a directed table, then random tick words
// over several register settings, each result checked against a cycle model of the timing.
// Depends on lmts_pkg, lmts_tick_if, lmts_result_if and the RTL top level.
module lcd_mode_timing_sequencer_tb
    import lmts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        bit      tick;
        bit      typed;
        t_result want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    lmts_tick_if   tick_ch ();
    lmts_result_if res_ch ();

    lcd_mode_timing_sequencer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (tick_ch),
        .o_result    (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // timing model state and register copy
    t_mode             mode_q;
    logic [LINE_W-1:0] line_q;
    logic [TICK_W-1:0] tick_cnt;
    logic              flag_q;
    logic [7:0]        cmp_val;
    logic              hb_en;
    logic              cmp_en;

    t_result timing_q[$];
    t_row    plan[$];
    int      err_cnt;
    int      quiet_cnt;
    bit      idle_en;
    bit      calm;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result advance_timing(bit tk);
        t_result r;
        logic    eq;
        r = '0;
        if (tk) begin
            tick_cnt = tick_cnt + 1'b1;
            case (mode_q)
                MODE_SCAN: begin
                    if (tick_cnt >= LEN_SCAN) begin
                        tick_cnt = '0;
                        mode_q   = MODE_XFER;
                    end
                end
                MODE_XFER: begin
                    if (tick_cnt >= LEN_XFER) begin
                        tick_cnt = '0;
                        eq = (line_q == cmp_val);
                        // both sources give one pulse
                        r.status_irq = hb_en || (cmp_en && eq);
                        flag_q = eq;
                        mode_q = MODE_HBLANK;
                    end
                end
                MODE_HBLANK: begin
                    if (tick_cnt >= LEN_HBLANK) begin
                        tick_cnt      = '0;
                        r.line_render = 1'b1;
                        line_q        = line_q + 1'b1;
                        if (line_q == FIRST_VBLANK_LINE) begin
                            mode_q       = MODE_VBLANK;
                            r.vblank_irq = 1'b1;
                        end else begin
                            mode_q = MODE_SCAN;
                        end
                    end
                end
                default: begin
                    if (tick_cnt >= LEN_LINE) begin
                        tick_cnt = '0;
                        line_q   = line_q + 1'b1;
                        if (line_q == LINE_COUNT) begin
                            r.frame_done = 1'b1;
                            line_q       = '0;
                            mode_q       = MODE_SCAN;
                        end
                    end
                end
            endcase
        end
        r.display_mode = mode_q;
        r.current_line = line_q;
        r.compare_flag = flag_q;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic add_row(bit tk, bit typed, t_result want);
        t_row row;
        row.tick  = tk;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // one tick word; the expectation is queued at the edge that accepts it
    task automatic send_word(bit tk, bit typed, t_result want);
        t_result pred;
        @(negedge i_clk);
        if (idle_en && !calm && $urandom_range(0, 7) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.tick  <= tk;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        pred = advance_timing(tk);
        timing_q.push_back(typed ? want : pred);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            REG_LINE_COMPARE: cmp_val = data;
            REG_HBLANK_EN:    hb_en   = data[0];
            REG_COMPARE_EN:   cmp_en  = data[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (timing_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [7:0] cmp, bit hb, bit ce, int n_words, int zero_pct,
                             bit idling);
        bit tk;
        drain();
        write_reg(REG_LINE_COMPARE, cmp);
        write_reg(REG_HBLANK_EN, {7'd0, hb});
        write_reg(REG_COMPARE_EN, {7'd0, ce});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        idle_en = idling;
        for (int k = 0; k < n_words; k++) begin
            tk = ($urandom_range(0, 99) >= zero_pct);
            send_word(tk, 1'b0, '0);
        end
        @(negedge i_clk);
        tick_ch.valid <= 1'b0;
    endtask

    // result side: random stall bursts
    initial begin : sink_side
        int stall;
        stall = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else if (idle_en && !calm && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                stall = $urandom_range(1, 9) - 1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // alternate stretches with and without idling
    initial begin
        calm = 1'b0;
        forever begin
            repeat ($urandom_range(40, 300)) @(posedge i_clk);
            calm = ~calm;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.display_mode, res_ch.current_line, res_ch.compare_flag,
                    res_ch.status_irq, res_ch.vblank_irq, res_ch.line_render,
                    res_ch.frame_done};
            if (timing_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h", got));
            end else begin
                want = timing_q.pop_front();
                if (got.display_mode !== want.display_mode)
                    report_mismatch($sformatf("display_mode got %h want %h",
                                              got.display_mode, want.display_mode));
                if (got.current_line !== want.current_line)
                    report_mismatch($sformatf("current_line got %0d want %0d",
                                              got.current_line, want.current_line));
                if (got.compare_flag !== want.compare_flag)
                    report_mismatch($sformatf("compare_flag got %b want %b",
                                              got.compare_flag, want.compare_flag));
                if (got.status_irq !== want.status_irq)
                    report_mismatch($sformatf("status_irq got %b want %b",
                                              got.status_irq, want.status_irq));
                if (got.vblank_irq !== want.vblank_irq)
                    report_mismatch($sformatf("vblank_irq got %b want %b",
                                              got.vblank_irq, want.vblank_irq));
                if (got.line_render !== want.line_render)
                    report_mismatch($sformatf("line_render got %b want %b",
                                              got.line_render, want.line_render));
                if (got.frame_done !== want.frame_done)
                    report_mismatch($sformatf("frame_done got %b want %b",
                                              got.frame_done, want.frame_done));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cnt <= 0;
        else if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("lcd_mode_timing_sequencer verification failed");
            $finish;
        end else
            quiet_cnt <= quiet_cnt + 1;
    end

    initial begin
        i_rst_n       = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.tick  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        err_cnt       = 0;
        quiet_cnt     = 0;
        idle_en       = 1'b1;
        mode_q        = MODE_SCAN;
        line_q        = '0;
        tick_cnt      = '0;
        flag_q        = 1'b0;
        cmp_val       = '0;
        hb_en         = 1'b0;
        cmp_en        = 1'b0;

        // directed: reset state, non-tick words, end of object scan
        add_row(1'b0, 1'b1, '{MODE_SCAN, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
        for (int k = 1; k < 20; k++) begin
            add_row(1'b1, 1'b0, '0);
            if (k == 10)
                add_row(1'b0, 1'b0, '0);
        end
        add_row(1'b1, 1'b1, '{MODE_XFER, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
        add_row(1'b0, 1'b1, '{MODE_XFER, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k])
            send_word(plan[k].tick, plan[k].typed, plan[k].want);
        @(negedge i_clk);
        tick_ch.valid <= 1'b0;

        // compare at line 0 with both enables: one status pulse for two sources
        run_phase(8'd0, 1'b1, 1'b1, 400, 15, 1'b1);
        run_phase(8'd255, 1'b1, 1'b0, 300, 3, 1'b1);
        // compare value within reach of the lines this run walks through
        run_phase(8'($urandom_range(5, 8)), 1'b0, 1'b1, 300, 3, 1'b1);
        run_phase(8'd153, 1'b0, 1'b0, 200, 2, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("lcd_mode_timing_sequencer verification clean");
        else
            $display("lcd_mode_timing_sequencer verification failed");
        $finish;
    end

endmodule
